>>> rtl/rcc_pkg.sv
`default_nettype none

package rcc_pkg;

    // sizing
    localparam int MAX_PIECES = 16;
    localparam int MAX_LENGTH = 64;

    // field widths
    localparam int LEN_W     = 7;
    localparam int PRICE_W   = 16;
    localparam int COST_W    = 16;
    localparam int ACT_W     = 2;
    localparam int OUT_VAL_W = 23;
    localparam int VAL_W     = 24;

    // derived widths
    localparam int CNT_W  = $clog2(MAX_PIECES + 1);
    localparam int IDX_W  = (MAX_PIECES > 1) ? $clog2(MAX_PIECES) : 1;
    localparam int ADDR_W = $clog2(MAX_LENGTH + 1);

    // action codes on the input tuser
    localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd1;
    localparam logic [ACT_W-1:0] ACT_SOLVE = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic             load;
        logic             clear;
        logic             issue;
        logic             acc_seed;
        logic             acc_clear;
        logic             emit;
        logic             out_en;
        logic             last;
        logic [IDX_W-1:0] idx;
        logic [LEN_W-1:0] len;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic [CNT_W-1:0] piece_count;
        logic             out_free;
    } t_dp_sts;

    // one result beat
    typedef struct packed {
        logic [LEN_W-1:0]     first_cut;
        logic [OUT_VAL_W-1:0] best_value;
        logic [LEN_W-1:0]     current_length;
        logic                 reachable;
        logic                 last;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/rod_cut_with_cut_cost.sv
// Rod cutting with a per-cut cost. A load beat (tuser 0) appends a piece of
// given length and price to a 16-entry table (loads into a full table are
// dropped), a clear beat (tuser 1) empties it, and a solve beat (tuser 2)
// gives a rod length L, saturated to 64. For every length 1..L one result
// beat follows with the best value, first cut and a reachable flag in tuser;
// the beat for L carries tlast. L of 0 gives a single beat of value 0.
// Load and clear are taken in idle and leave the input open. During a solve
// the compare loop examines one table entry per cycle through a registered
// read of the best-value memory, and each length then passes through a drain
// state and a write-back state, which waits while the output is stalled.
// The input is not ready while a solve runs. cut_cost is written through
// i_cfg_we/i_cfg_wdata.
`default_nettype none

module rod_cut_with_cut_cost
    import rcc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [COST_W-1:0] i_cfg_wdata,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    // [6:0] piece_length, [22:7] piece_price, [29:23] rod_length, [31:30] zero
    input  wire logic [31:0]       s_axis_tdata,
    // [1:0] action
    input  wire logic [ACT_W-1:0]  s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    // [6:0] current_length, [29:7] best_value, [36:30] first_cut, [39:37] zero
    output logic [39:0]            m_axis_tdata,
    // [0] reachable
    output logic                   m_axis_tuser,
    output logic                   m_axis_tlast
);

    t_dp_cmd cmd;
    t_dp_sts sts;
    t_result result;

    rcc_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_action     (s_axis_tuser),
        .i_rod_length (s_axis_tdata[29:23]),
        .i_sts        (sts),
        .o_cmd        (cmd)
    );

    rcc_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_piece_length (s_axis_tdata[6:0]),
        .i_piece_price  (s_axis_tdata[22:7]),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_result       (result)
    );

    // result beat packing
    assign m_axis_tdata = {3'b000, result.first_cut, result.best_value,
                           result.current_length};
    assign m_axis_tuser = result.reachable;
    assign m_axis_tlast = result.last;

endmodule

`default_nettype wire

>>> rtl/rcc_ctrl.sv
`default_nettype none

module rcc_ctrl
    import rcc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire logic [ACT_W-1:0] i_action,
    input  wire logic [LEN_W-1:0] i_rod_length,
    input  wire t_dp_sts          i_sts,
    output t_dp_cmd               o_cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [LEN_W-1:0] r_i, n_i;
    logic [LEN_W-1:0] r_rod, n_rod;
    logic [IDX_W-1:0] r_j, n_j;

    assign o_in_ready = (r_state == ST_IDLE);

    // sequencing: one piece per cycle, then drain, then write back and emit
    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_rod   = r_rod;
        n_j     = r_j;
        o_cmd        = '0;
        o_cmd.idx    = r_j;
        o_cmd.len    = r_i;
        o_cmd.last   = (r_i == r_rod);
        // length 0 is only reported when it is the requested rod
        o_cmd.out_en = (r_i != '0) || (r_rod == '0);
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_action)
                        ACT_LOAD:  o_cmd.load = 1'b1;
                        ACT_CLEAR: o_cmd.clear = 1'b1;
                        ACT_SOLVE: begin
                            n_rod = (i_rod_length > LEN_W'(MAX_LENGTH)) ?
                                    LEN_W'(MAX_LENGTH) : i_rod_length;
                            n_i   = '0;
                            o_cmd.acc_seed = 1'b1;
                            n_state = ST_EMIT;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                o_cmd.issue = 1'b1;
                if (CNT_W'(r_j) + CNT_W'(1) == i_sts.piece_count) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            ST_DRAIN: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_sts.out_free || !o_cmd.out_en) begin
                    o_cmd.emit = 1'b1;
                    if (o_cmd.last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_i = r_i + 1'b1;
                        n_j = '0;
                        o_cmd.acc_clear = 1'b1;
                        n_state = (i_sts.piece_count == '0) ? ST_DRAIN : ST_SCAN;
                    end
                end
            end
        endcase
    end

    // state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_i     <= '0;
            r_rod   <= '0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_rod   <= n_rod;
            r_j     <= n_j;
        end
    end

endmodule

`default_nettype wire

>>> rtl/rcc_dp.sv
`default_nettype none

module rcc_dp
    import rcc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_dp_cmd            i_cmd,
    output t_dp_sts                 o_sts,
    input  wire logic [LEN_W-1:0]   i_piece_length,
    input  wire logic [PRICE_W-1:0] i_piece_price,
    input  wire logic               i_cfg_we,
    input  wire logic [COST_W-1:0]  i_cfg_wdata,
    input  wire logic               i_out_ready,
    output logic                    o_out_valid,
    output t_result                 o_result
);

    logic [COST_W-1:0]  r_cut_cost;
    logic [CNT_W-1:0]   r_count;
    logic [LEN_W-1:0]   r_pl_tab [MAX_PIECES];
    logic [PRICE_W-1:0] r_pr_tab [MAX_PIECES];

    // best value memory: {reachable, value}
    logic [VAL_W:0]     r_mem [MAX_LENGTH+1];
    logic [VAL_W:0]     r_rd;
    logic [ADDR_W-1:0]  rd_addr;

    logic [LEN_W-1:0]   pl;
    logic               fit;
    logic               r_s1_valid;
    logic               r_s1_fit;
    logic [LEN_W-1:0]   r_s1_pl;
    logic [PRICE_W-1:0] r_s1_price;

    logic [VAL_W-1:0]   cut_sub;
    logic [VAL_W-1:0]   profit;
    logic               take;

    logic               r_found;
    logic [VAL_W-1:0]   r_best;
    logic [LEN_W-1:0]   r_cut;

    logic               r_out_valid;
    t_result            r_result;

    // cut cost register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cut_cost <= '0;
        end else if (i_cfg_we) begin
            r_cut_cost <= i_cfg_wdata;
        end
    end

    // piece count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.clear) begin
            r_count <= '0;
        end else if (i_cmd.load && (r_count < CNT_W'(MAX_PIECES))) begin
            r_count <= r_count + 1'b1;
        end
    end

    // piece table, appended at the count
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (r_count < CNT_W'(MAX_PIECES))) begin
            r_pl_tab[r_count[IDX_W-1:0]] <= i_piece_length;
            r_pr_tab[r_count[IDX_W-1:0]] <= i_piece_price;
        end
    end

    // stage 0: fetch piece, form remainder address
    assign pl      = r_pl_tab[i_cmd.idx];
    assign fit     = (pl != '0) && (pl <= i_cmd.len);
    assign rd_addr = ADDR_W'(i_cmd.len - pl);

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_mem[i_cmd.len[ADDR_W-1:0]] <= {r_found, r_best};
        end
        r_rd <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_cmd.issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_fit   <= fit;
        r_s1_pl    <= pl;
        r_s1_price <= r_pr_tab[i_cmd.idx];
    end

    // stage 1: profit and running best, earliest entry wins ties
    assign cut_sub = (r_s1_pl != i_cmd.len) ? VAL_W'(r_cut_cost) : '0;
    assign profit  = VAL_W'(r_s1_price) + r_rd[VAL_W-1:0] - cut_sub;
    assign take    = r_s1_valid && r_s1_fit && r_rd[VAL_W] &&
                     (!r_found || ($signed(profit) > $signed(r_best)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_cmd.acc_seed) begin
            r_found <= 1'b1;
        end else if (i_cmd.acc_clear) begin
            r_found <= 1'b0;
        end else if (take) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_seed || i_cmd.acc_clear) begin
            r_best <= '0;
            r_cut  <= '0;
        end else if (take) begin
            r_best <= profit;
            r_cut  <= r_s1_pl;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit && i_cmd.out_en) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit && i_cmd.out_en) begin
            r_result.current_length <= i_cmd.len;
            r_result.best_value     <= r_best[OUT_VAL_W-1:0];
            r_result.first_cut      <= r_cut;
            r_result.reachable      <= r_found;
            r_result.last           <= i_cmd.last;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_result          = r_result;
    assign o_sts.piece_count = r_count;
    assign o_sts.out_free    = !r_out_valid || i_out_ready;

endmodule

`default_nettype wire

>>> rtl/rcc_checker.sv
`default_nettype none

module rcc_checker
    import rcc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              s_axis_tvalid,
    input  wire logic              s_axis_tready,
    input  wire logic [ACT_W-1:0]  s_axis_tuser,
    input  wire logic              m_axis_tvalid,
    input  wire logic              m_axis_tready,
    input  wire logic [39:0]       m_axis_tdata,
    input  wire logic              m_axis_tuser,
    input  wire logic              m_axis_tlast
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("result beat changed while stalled");

    // an accepted solve closes the input
    a_solve_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACT_SOLVE)) |=>
        !s_axis_tready)
        else $error("input ready during solve");

    // load, clear and unused codes leave the input open
    a_quick_ops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser != ACT_SOLVE)) |=>
        s_axis_tready)
        else $error("input closed after non-solve beat");

    // unreachable lengths report zero value and no cut
    a_unreach_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |->
        ((m_axis_tdata[29:7] == '0) && (m_axis_tdata[36:30] == '0)))
        else $error("unreachable result with nonzero fields");

    // length zero only appears as the sole, reachable, zero result
    a_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[6:0] == '0)) |->
        (m_axis_tlast && m_axis_tuser && (m_axis_tdata[36:7] == '0)))
        else $error("bad result for rod length zero");

endmodule

bind rod_cut_with_cut_cost rcc_checker u_rcc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
